[hdl/sspq_pkg.sv]
// Shared types, constants and codes of the scored sorted priority queue.
`default_nettype none

package sspq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int GRADE_LIMIT_DEF = 1000;
    localparam int COURSE_GOAL_DEF = 40;

    localparam int PAYLOAD_W = 16;
    localparam int GRADE_W   = 12;
    localparam int COURSES_W = 8;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam int QUOT_W      = 15;
    localparam int NUM_W       = 21;
    localparam int SCALE_SHIFT = 14;
    localparam int RECIP_SHIFT = 41;
    localparam int RECIP_W     = RECIP_SHIFT + SCALE_SHIFT + 1;

    localparam logic [PRIO_W-1:0] PRIO_ONE = 16'd32768;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                 req_type;
        logic [PAYLOAD_W-1:0] payload;
        logic [GRADE_W-1:0]   grade_hundredths;
        logic [COURSES_W-1:0] courses_done;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OCC_W-1:0]     occupancy;
        logic                 is_empty;
        logic [PAYLOAD_W-1:0] head_payload;
        logic [GRADE_W-1:0]   head_grade;
        logic [COURSES_W-1:0] head_courses;
        logic [PRIO_W-1:0]    head_priority;
    } rsp_word_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [GRADE_W-1:0]   grade;
        logic [COURSES_W-1:0] courses;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic mul_step;
        logic sum_step;
        logic apply;
        logic load_rsp;
    } dp_cmd_t;

endpackage

`default_nettype wire

[hdl/scored_sorted_priority_queue_top.sv]
// Bounded priority queue with score computation, kept sorted in descending priority.
//
// One request word in gives one response word out. Each request passes through these steps
// in order: the accepting cycle captures it and forms the score numerator, a multiply step
// multiplies the numerator by the precomputed reciprocal of the denominator in two halves,
// a sum step sums the halves into the Q1.15 score, an apply step inserts into or shifts
// the sorted entry cells, and a report step loads the response word, which is valid once
// loaded. The next request is taken the cycle after the response is loaded, so a new
// request waits until the previous one is answered; a response held by stall keeps the
// block in its report step. Enqueues on a full queue and dequeues on an empty one leave
// the entries unchanged and report it in the status field. The entry store needs no clearing after reset.
`default_nettype none

module scored_sorted_priority_queue_top #(
    parameter int CAPACITY    = sspq_pkg::CAPACITY_DEF,
    parameter int GRADE_LIMIT = sspq_pkg::GRADE_LIMIT_DEF,
    parameter int COURSE_GOAL = sspq_pkg::COURSE_GOAL_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire sspq_pkg::req_word_t req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output sspq_pkg::rsp_word_t      rsp_word
);

    sspq_pkg::dp_cmd_t cmd;

    sspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    sspq_dpath #(
        .CAPACITY    (CAPACITY),
        .GRADE_LIMIT (GRADE_LIMIT),
        .COURSE_GOAL (COURSE_GOAL)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .rsp_word (rsp_word)
    );

endmodule

`default_nettype wire

[hdl/sspq_dpath.sv]
// Datapath: request capture, reciprocal scoring, sorted entry cells and response register.
`default_nettype none

module sspq_dpath #(
    parameter int CAPACITY    = sspq_pkg::CAPACITY_DEF,
    parameter int GRADE_LIMIT = sspq_pkg::GRADE_LIMIT_DEF,
    parameter int COURSE_GOAL = sspq_pkg::COURSE_GOAL_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sspq_pkg::dp_cmd_t cmd,
    input  wire sspq_pkg::req_word_t req_word,
    output sspq_pkg::rsp_word_t    rsp_word
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int NUM_W  = sspq_pkg::NUM_W;
    localparam int HALF_W = sspq_pkg::RECIP_W / 2;
    localparam int PROD_W = NUM_W + HALF_W;
    localparam int SUM_W  = PROD_W + HALF_W;
    localparam logic [NUM_W:0] TWO_DEN =
        (NUM_W+1)'(2 * GRADE_LIMIT * COURSE_GOAL);
    localparam logic [63:0] DEN_WIDE = 64'(GRADE_LIMIT) * 64'(COURSE_GOAL);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (sspq_pkg::RECIP_SHIFT + sspq_pkg::SCALE_SHIFT)) + DEN_WIDE - 64'd1)
        / DEN_WIDE;
    localparam logic [HALF_W-1:0] RECIP_LO = HALF_W'(RECIP_WIDE);
    localparam logic [HALF_W-1:0] RECIP_HI = HALF_W'(RECIP_WIDE >> HALF_W);

    sspq_pkg::req_word_t           req_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [PROD_W-1:0]             prod_lo_reg, prod_hi_reg;
    logic [SUM_W-1:0]              prod_sum;
    logic [sspq_pkg::QUOT_W-1:0]   quot_reg;
    logic                          sat_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [sspq_pkg::STATUS_W-1:0] status_reg, status_next;
    sspq_pkg::rsp_word_t           rsp_reg;
    sspq_pkg::entry_t              store_reg [CAPACITY];
    sspq_pkg::entry_t              store_next [CAPACITY];
    sspq_pkg::entry_t              new_entry;
    logic [CAPACITY-1:0]           ge;
    logic                          full, empty, do_write;
    logic [NUM_W-1:0]              num;

    assign num = NUM_W'(req_word.grade_hundredths) * NUM_W'(COURSE_GOAL)
               + NUM_W'(req_word.courses_done) * NUM_W'(GRADE_LIMIT);

    assign prod_sum = {prod_hi_reg, {HALF_W{1'b0}}} + SUM_W'(prod_lo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_word;
            num_reg <= num;
            sat_reg <= {1'b0, num} >= TWO_DEN;
        end
        if (cmd.mul_step)
        begin
            prod_lo_reg <= PROD_W'(num_reg) * PROD_W'(RECIP_LO);
            prod_hi_reg <= PROD_W'(num_reg) * PROD_W'(RECIP_HI);
        end
        if (cmd.sum_step)
            quot_reg <= prod_sum[sspq_pkg::RECIP_SHIFT +: sspq_pkg::QUOT_W];
    end

    assign full  = count_reg == CNT_W'(CAPACITY);
    assign empty = count_reg == '0;

    assign new_entry.payload = req_reg.payload;
    assign new_entry.grade   = req_reg.grade_hundredths;
    assign new_entry.courses = req_reg.courses_done;
    assign new_entry.prio    = sat_reg ? sspq_pkg::PRIO_ONE : {1'b0, quot_reg};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign ge[i] = (CNT_W'(i) < count_reg) && (store_reg[i].prio >= new_entry.prio);

        always_comb
        begin
            if (req_reg.req_type == sspq_pkg::REQ_ENQ)
            begin
                if (ge[i])
                    store_next[i] = store_reg[i];
                else if (i == 0)
                    store_next[i] = new_entry;
                else if (ge[(i == 0) ? 0 : i-1])
                    store_next[i] = new_entry;
                else
                    store_next[i] = store_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                store_next[i] = store_reg[(i == CAPACITY-1) ? i : i+1];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = sspq_pkg::STATUS_DONE;
        do_write    = 1'b0;
        if (req_reg.req_type == sspq_pkg::REQ_ENQ)
        begin
            if (full)
                status_next = sspq_pkg::STATUS_FULL;
            else
            begin
                count_next = count_reg + 1'b1;
                do_write   = 1'b1;
            end
        end
        else
        begin
            if (empty)
                status_next = sspq_pkg::STATUS_EMPTY;
            else
            begin
                count_next = count_reg - 1'b1;
                do_write   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && do_write)
        begin
            for (int i = 0; i < CAPACITY; i++)
                store_reg[i] <= store_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.apply)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
            status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.status    <= status_reg;
            rsp_reg.occupancy <= sspq_pkg::OCC_W'(count_reg);
            rsp_reg.is_empty  <= empty;
            if (empty)
            begin
                rsp_reg.head_payload  <= '0;
                rsp_reg.head_grade    <= '0;
                rsp_reg.head_courses  <= '0;
                rsp_reg.head_priority <= '0;
            end
            else
            begin
                rsp_reg.head_payload  <= store_reg[0].payload;
                rsp_reg.head_grade    <= store_reg[0].grade;
                rsp_reg.head_courses  <= store_reg[0].courses;
                rsp_reg.head_priority <= store_reg[0].prio;
            end
        end
    end

    assign rsp_word = rsp_reg;

endmodule

`default_nettype wire

[hdl/sspq_ctrl.sv]
// Controller: sequences capture, scoring, store update and response hand-off.
`default_nettype none

module sspq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output sspq_pkg::dp_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       rsp_free;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (rsp_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire
